>>> rtl/core/matrix_add_sub_multiply_top_defines.svh
// Assertion macros for the matrix add/subtract/multiply engine.
`ifndef MATRIX_ADD_SUB_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_ADD_SUB_MULTIPLY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define MAS_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define MAS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAS_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons, msg)
`define MAS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg)
`endif

`endif

>>> rtl/core/mas_pkg.sv
// Shared types, codes and helpers of the matrix add/subtract/multiply engine.
`timescale 1ns / 1ps
package mas_pkg;

	localparam int MAX_DIM_DEF      = 8;
	localparam int ELEMENT_BITS_DEF = 16;

	localparam int ELEM_PORT_W = 16;
	localparam int VALUE_W     = 35;
	localparam int POS_W       = 3;
	localparam int DIM_REG_W   = 4;
	localparam int OP_W        = 2;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OP     = 3'd4;

	// result status
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHAPE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_RSUB = 2'd2,
		OP_MUL  = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} fsm_t;

	// per-term control carried down the datapath
	typedef struct packed {
		logic             valid;
		logic             first;   // first term of a dot product
		logic             lastk;   // term closes the result element
		logic             last;    // final element of the run
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} tag_t;

	// zero reads as one, above the limit reads as the limit
	function automatic logic [DIM_REG_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] r,
		input int unsigned maxd);
		logic [DIM_REG_W-1:0] d;
		if (r == '0)
			d = DIM_REG_W'(1);
		else if (int'(r) > maxd)
			d = DIM_REG_W'(maxd);
		else
			d = r;
		return d;
	endfunction

endpackage

>>> rtl/core/matrix_add_sub_multiply_top.sv
// Matrix add/subtract/multiply engine with shared multiply-accumulate datapath.
`timescale 1ns / 1ps
`include "matrix_add_sub_multiply_top_defines.svh"
//
// Channel   Signals                                  Transfer
// --------  ---------------------------------------  ------------------------------
// command   start, busy, opcode, element             beat when start && !busy
// result    strobe, row, column, value, status, last one beat per strobe cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data beat when cfg_valid && cfg_ready
//
// Loads leave busy low, so a load can follow every cycle. A compute walks the
// stored elements through one read port per store and one shared multiply/add
// unit: rows*cols terms for A+B, A-B, B-A and rows*cols*a_cols terms for A times
// B, one term per cycle; busy drops once the pipeline has drained. A term passes
// the read (tag_s1), term (tag_s2) and result registers before its result shows.
// A shape mismatch gives its single error beat the cycle after the command.
// Reset sets dimensions to one and the operation to add, and clears fill counts
// and control; stores are undefined until loaded. Results cannot be held off:
// each beat is shown for one cycle.
module matrix_add_sub_multiply_top #(
	parameter int MAX_DIM      = mas_pkg::MAX_DIM_DEF,
	parameter int ELEMENT_BITS = mas_pkg::ELEMENT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [mas_pkg::CMD_W-1:0]             opcode,
	input  logic signed [mas_pkg::ELEM_PORT_W-1:0] element,
	// result channel
	output logic                                  strobe,
	output logic [mas_pkg::POS_W-1:0]             row,
	output logic [mas_pkg::POS_W-1:0]             column,
	output logic signed [mas_pkg::VALUE_W-1:0]    value,
	output logic                                  status,
	output logic                                  last,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mas_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mas_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import mas_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PROD_W = 2 * ELEMENT_BITS;

	// ---------------- configuration registers ----------------
	logic [DIM_REG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	op_t                  op_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_REG_W'(1);
			a_cols_q <= DIM_REG_W'(1);
			b_rows_q <= DIM_REG_W'(1);
			b_cols_q <= DIM_REG_W'(1);
			op_q     <= OP_ADD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				REG_OP:     op_q     <= op_t'(cfg_data[OP_W-1:0]);
				default: ;
			endcase
		end
	end

	// effective shapes
	logic [DIM_W-1:0] ar_c, ac_c, br_c, bc_c;
	assign ar_c = DIM_W'(clamp_dim(a_rows_q, MAX_DIM));
	assign ac_c = DIM_W'(clamp_dim(a_cols_q, MAX_DIM));
	assign br_c = DIM_W'(clamp_dim(b_rows_q, MAX_DIM));
	assign bc_c = DIM_W'(clamp_dim(b_cols_q, MAX_DIM));

	logic mismatch;
	assign mismatch = (op_q == OP_MUL) ? (ac_c != br_c) : ((ar_c != br_c) || (ac_c != bc_c));

	// ---------------- command decode ----------------
	fsm_t state_q, state_d;
	tag_t tag_s1, tag_s2;
	logic accept, do_load_a, do_load_b, do_compute;

	assign busy   = (state_q == ST_RUN) || tag_s1.valid || tag_s2.valid;
	assign accept = start && !busy;

	always_comb begin
		do_load_a  = 1'b0;
		do_load_b  = 1'b0;
		do_compute = 1'b0;
		if (accept) begin
			unique case (opcode)
				CMD_LOAD_A:  do_load_a  = 1'b1;
				CMD_LOAD_B:  do_load_b  = 1'b1;
				CMD_COMPUTE: do_compute = 1'b1;
				default: ;
			endcase
		end
	end

	// ---------------- fill counts ----------------
	logic [FILL_W-1:0] fill_a_q, fill_b_q;
	logic              wr_a, wr_b;

	assign wr_a = do_load_a && (fill_a_q < FILL_W'(DEPTH));
	assign wr_b = do_load_b && (fill_b_q < FILL_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_a_q <= '0;
			fill_b_q <= '0;
		end else if (do_compute) begin
			fill_a_q <= '0;
			fill_b_q <= '0;
		end else begin
			if (wr_a)
				fill_a_q <= fill_a_q + 1'b1;
			if (wr_b)
				fill_b_q <= fill_b_q + 1'b1;
		end
	end

	// ---------------- sequencer ----------------
	logic [DIM_W-1:0]  rows_q, cols_q, inner_q, bstride_q;
	op_t               run_op_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [ADDR_W-1:0] a_base_q, kbase_q;
	logic              kend, jend, iend, run_mul;
	logic [ADDR_W-1:0] a_addr, b_addr;

	assign run_mul = (run_op_q == OP_MUL);
	assign kend    = !run_mul || (k_q == IDX_W'(inner_q - 1'b1));
	assign jend    = (j_q == IDX_W'(cols_q - 1'b1));
	assign iend    = (i_q == IDX_W'(rows_q - 1'b1));
	assign a_addr  = a_base_q + ADDR_W'(run_mul ? k_q : j_q);
	assign b_addr  = run_mul ? (kbase_q + ADDR_W'(j_q)) : a_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (do_compute && !mismatch) state_d = ST_RUN;
			ST_RUN:  if (kend && jend && iend) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			kbase_q  <= '0;
		end else if (state_q == ST_IDLE) begin
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			kbase_q  <= '0;
		end else if (!kend) begin
			k_q     <= k_q + 1'b1;
			kbase_q <= kbase_q + ADDR_W'(bstride_q);
		end else begin
			k_q     <= '0;
			kbase_q <= '0;
			if (!jend) begin
				j_q <= j_q + 1'b1;
			end else begin
				j_q      <= '0;
				i_q      <= i_q + 1'b1;
				a_base_q <= a_base_q + ADDR_W'(inner_q);
			end
		end
	end

	// run shape, latched at the compute command
	always_ff @(posedge clk) begin
		if (do_compute) begin
			rows_q    <= ar_c;
			cols_q    <= (op_q == OP_MUL) ? bc_c : ac_c;
			inner_q   <= ac_c;
			bstride_q <= bc_c;
			run_op_q  <= op_q;
		end
	end

	// ---------------- element stores ----------------
	logic signed [ELEMENT_BITS-1:0] mem_a [DEPTH];
	logic signed [ELEMENT_BITS-1:0] mem_b [DEPTH];
	logic signed [ELEMENT_BITS-1:0] ra_s1, rb_s1;
	logic signed [ELEMENT_BITS-1:0] elem_w;

	// port bits taken as ELEMENT_BITS two's complement
	assign elem_w = ELEMENT_BITS'($unsigned(element));

	always_ff @(posedge clk) begin
		if (wr_a)
			mem_a[fill_a_q[ADDR_W-1:0]] <= elem_w;
		if (state_q == ST_RUN)
			ra_s1 <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			mem_b[fill_b_q[ADDR_W-1:0]] <= elem_w;
		if (state_q == ST_RUN)
			rb_s1 <= mem_b[b_addr];
	end

	// ---------------- shared arithmetic pipeline ----------------
	tag_t issue_tag;

	always_comb begin
		issue_tag.valid = (state_q == ST_RUN);
		issue_tag.first = (k_q == '0);
		issue_tag.lastk = kend;
		issue_tag.last  = kend && jend && iend;
		issue_tag.row   = POS_W'(i_q);
		issue_tag.col   = POS_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= issue_tag;
			tag_s2 <= tag_s1;
		end
	end

	logic signed [PROD_W-1:0]  prod;
	logic signed [VALUE_W-1:0] xa, yb, term, term_s2, acc_q, sum;

	assign prod = ra_s1 * rb_s1;
	assign xa   = VALUE_W'(ra_s1);
	assign yb   = VALUE_W'(rb_s1);

	always_comb begin
		case (run_op_q)
			OP_ADD:  term = xa + yb;
			OP_SUB:  term = xa - yb;
			OP_RSUB: term = yb - xa;
			default: term = VALUE_W'(prod);
		endcase
	end

	always_ff @(posedge clk) begin
		term_s2 <= term;
	end

	// accumulate; wraps at the result width
	assign sum = tag_s2.first ? term_s2 : (acc_q + term_s2);

	always_ff @(posedge clk) begin
		if (tag_s2.valid)
			acc_q <= sum;
	end

	// ---------------- result register ----------------
	logic                    strobe_q, status_q, last_q;
	logic [POS_W-1:0]        row_q, col_q;
	logic signed [VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (tag_s2.valid && tag_s2.lastk) || (do_compute && mismatch);
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.lastk) begin
			row_q    <= tag_s2.row;
			col_q    <= tag_s2.col;
			value_q  <= sum;
			status_q <= STATUS_OK;
			last_q   <= tag_s2.last;
		end else if (do_compute && mismatch) begin
			row_q    <= '0;
			col_q    <= '0;
			value_q  <= '0;
			status_q <= STATUS_SHAPE;
			last_q   <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign row    = row_q;
	assign column = col_q;
	assign value  = value_q;
	assign status = status_q;
	assign last   = last_q;

	// ---------------- checks ----------------
	`MAS_ASSERT_IMPLY(a_run_fills_clear, clk, arst_n, state_q == ST_RUN, (fill_a_q == '0) && (fill_b_q == '0), "fill count moved during a compute run")
	`MAS_ASSERT_NEXT(a_compute_starts, clk, arst_n, do_compute && !mismatch, state_q == ST_RUN, "compute command did not start a run")
	`MAS_ASSERT_NEXT(a_mismatch_err, clk, arst_n, do_compute && mismatch, strobe && (status == STATUS_SHAPE) && last, "shape mismatch gave no error beat")
	`MAS_ASSERT_IMPLY(a_last_idle, clk, arst_n, strobe && last, !busy, "final beat left work in flight")

endmodule
